@@ rtl/core/kmer_spectrum_counter_unit_assert.svh @@
// assertion macros for the tuple counter unit
`ifndef KMER_SPECTRUM_COUNTER_UNIT_ASSERT_SVH
`define KMER_SPECTRUM_COUNTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define KSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ksc assertion failed");
`define KSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ksc assertion failed");
`else
`define KSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/ksc_pkg.sv @@
// shared constants and helpers of the tuple counter unit
package ksc_pkg;

    localparam int MAX_TUPLE_LEN_DEF = 10;
    localparam int LEN_W             = 4;
    localparam int CNT_W             = 8;
    localparam int INDEX_W           = 20;
    localparam int CHAR_W            = 8;
    localparam int CFG_INDEX_W       = 2;
    localparam int QUEUE_DEPTH       = 4;
    localparam int OUT_DATA_W        = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_TUPLE_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MULTIPLICITY = 2'd1;

    localparam logic [LEN_W-1:0] TUPLE_LENGTH_RST = 4'd10;
    localparam logic [CNT_W-1:0] MULTIPLICITY_RST = 8'd1;

    localparam logic OP_BASE = 1'b0;
    localparam logic OP_SCAN = 1'b1;

    localparam logic KIND_TUPLE = 1'b0;
    localparam logic KIND_SCAN  = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    function automatic logic [1:0] base_code(input logic [CHAR_W-1:0] ch);
        logic [1:0] code;
        unique case (ch)
            CHAR_C:  code = CODE_C;
            CHAR_G:  code = CODE_G;
            CHAR_T:  code = CODE_T;
            default: code = CODE_A;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/core/ksc_ram.sv @@
// generic single-port ram with registered read
module ksc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/ksc_front.sv @@
// front end: takes items, builds tuples, steps the scan pointer
module ksc_front #(
    parameter int MAX_TUPLE_LEN = ksc_pkg::MAX_TUPLE_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ksc_pkg::LEN_W-1:0]   i_len,
    input  logic                        i_clear_done,
    input  logic                        i_q_full,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [ksc_pkg::CHAR_W-1:0]  s_axis_tdata,   // base_char
    input  logic                        s_axis_tuser,   // opcode
    output logic                        o_q_push,
    output logic [2*MAX_TUPLE_LEN+1:0]  o_q_data
);

    localparam int IW = 2 * MAX_TUPLE_LEN;

    logic [IW-1:0]             r_acc, n_acc;
    logic [ksc_pkg::LEN_W-1:0] r_pos, n_pos;
    logic [IW-1:0]             r_ptr, n_ptr;

    logic                      w_accept;
    logic [ksc_pkg::LEN_W:0]   w_shamt;
    logic [IW-1:0]             w_mask;
    logic [IW-1:0]             w_acc_shift;
    logic [ksc_pkg::LEN_W-1:0] w_pos_inc;
    logic                      w_complete;
    logic [IW-1:0]             w_ptr_eff;
    logic                      w_last;

    assign s_axis_tready = i_clear_done && !i_q_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_shamt     = {i_len, 1'b0};
    assign w_mask      = ~({IW{1'b1}} << w_shamt);
    assign w_acc_shift = IW'({r_acc, ksc_pkg::base_code(s_axis_tdata)});
    assign w_pos_inc   = r_pos + 1'b1;
    assign w_complete  = (w_pos_inc >= i_len);
    assign w_ptr_eff   = ((r_ptr & ~w_mask) != '0) ? '0 : r_ptr;
    assign w_last      = (w_ptr_eff == w_mask);

    always_comb begin
        n_acc    = r_acc;
        n_pos    = r_pos;
        n_ptr    = r_ptr;
        o_q_push = 1'b0;
        o_q_data = {1'b0, ksc_pkg::KIND_TUPLE, w_acc_shift & w_mask};
        if (w_accept) begin
            unique case (s_axis_tuser)
                ksc_pkg::OP_BASE: begin
                    if (w_complete) begin
                        o_q_push = 1'b1;
                        n_acc    = '0;
                        n_pos    = '0;
                    end else begin
                        n_acc = w_acc_shift;
                        n_pos = w_pos_inc;
                    end
                end
                ksc_pkg::OP_SCAN: begin
                    o_q_push = 1'b1;
                    o_q_data = {w_last, ksc_pkg::KIND_SCAN, w_ptr_eff};
                    n_ptr    = w_last ? '0 : w_ptr_eff + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_pos <= '0;
            r_ptr <= '0;
        end else begin
            r_acc <= n_acc;
            r_pos <= n_pos;
            r_ptr <= n_ptr;
        end
    end

endmodule

@@ rtl/core/ksc_queue.sv @@
// small fifo between front end and back end
module ksc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ksc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

endmodule

@@ rtl/core/ksc_back.sv @@
// back end: clears the counter store, runs counter updates and scan reads
module ksc_back #(
    parameter int MAX_TUPLE_LEN = ksc_pkg::MAX_TUPLE_LEN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [ksc_pkg::CNT_W-1:0]        i_mult,
    input  logic                             i_q_empty,
    input  logic [2*MAX_TUPLE_LEN+1:0]       i_q_data,
    output logic                             o_q_pop,
    output logic                             o_clear_done,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tuple_index, tuple_count, qualifies, zero fill
    output logic [ksc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tuser,   // result_kind
    output logic                             m_axis_tlast    // scan_last
);

    localparam int IW    = 2 * MAX_TUPLE_LEN;
    localparam int DEPTH = 1 << IW;
    localparam int PAD_W = ksc_pkg::OUT_DATA_W - ksc_pkg::INDEX_W - ksc_pkg::CNT_W - 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DATA
    } t_state;

    t_state                      r_state;
    logic [IW-1:0]               r_clr_addr;
    logic [IW-1:0]               r_idx;
    logic                        r_kind;
    logic                        r_last;
    logic                        r_out_valid;
    logic [ksc_pkg::INDEX_W-1:0] r_out_idx;
    logic [ksc_pkg::CNT_W-1:0]   r_out_cnt;
    logic                        r_out_qual;
    logic                        r_out_kind;
    logic                        r_out_last;

    logic                        w_ram_we;
    logic                        w_ram_re;
    logic [IW-1:0]               w_ram_addr;
    logic [ksc_pkg::CNT_W-1:0]   w_ram_wdata;
    logic [ksc_pkg::CNT_W-1:0]   w_ram_rdata;
    logic                        w_out_free;
    logic                        w_inc;
    logic [ksc_pkg::CNT_W-1:0]   w_cnt_new;
    logic [IW+ksc_pkg::INDEX_W-1:0] w_idx_ext;

    ksc_ram #(
        .WIDTH (ksc_pkg::CNT_W),
        .DEPTH (DEPTH)
    ) u_counters (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_re    (w_ram_re),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_inc      = (r_kind == ksc_pkg::KIND_TUPLE) && (w_ram_rdata < i_mult);
    assign w_cnt_new  = w_inc ? w_ram_rdata + 1'b1 : w_ram_rdata;
    assign w_idx_ext  = {{ksc_pkg::INDEX_W{1'b0}}, r_idx};

    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_re    = 1'b0;
        w_ram_addr  = r_idx;
        w_ram_wdata = w_cnt_new;
        o_q_pop     = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_addr  = r_clr_addr;
                w_ram_wdata = '0;
            end
            S_IDLE: begin
                o_q_pop    = !i_q_empty;
                w_ram_re   = !i_q_empty;
                w_ram_addr = i_q_data[IW-1:0];
            end
            S_DATA: begin
                w_ram_we = w_out_free && w_inc;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == IW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_idx   <= i_q_data[IW-1:0];
                        r_kind  <= i_q_data[IW];
                        r_last  <= i_q_data[IW+1];
                        r_state <= S_DATA;
                    end
                end
                S_DATA: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= w_idx_ext[ksc_pkg::INDEX_W-1:0];
                        r_out_cnt   <= w_cnt_new;
                        r_out_qual  <= (w_cnt_new >= i_mult);
                        r_out_kind  <= r_kind;
                        r_out_last  <= r_last;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_clear_done  = (r_state != S_CLEAR);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_qual, r_out_cnt, r_out_idx};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule

@@ rtl/core/kmer_spectrum_counter_unit.sv @@
// top level of the tuple counter unit: config registers, front end, queue, back end
//
// channel  direction  handshake                       payload
// s_axis   in         s_axis_tvalid / s_axis_tready   tdata base_char, tuser opcode
// m_axis   out        m_axis_tvalid / m_axis_tready   tdata index/count/qualifies, tuser kind,
//                                                     tlast scan_last
// cfg      in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// the front end takes one item per cycle while the queue has room
// each tuple or scan item uses the single counter ram port in the back end (read in S_IDLE,
// then update and result in S_DATA), so the back end pops a new item only after the last one
// is through; after reset the back end clears all 4^MAX_TUPLE_LEN counter ram words with
// s_axis_tready low; config transfers are taken throughout
// a stalled m_axis holds the back end and, once the queue fills, s_axis
`include "kmer_spectrum_counter_unit_assert.svh"
module kmer_spectrum_counter_unit #(
    parameter int MAX_TUPLE_LEN = ksc_pkg::MAX_TUPLE_LEN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ksc_pkg::CHAR_W-1:0]          s_axis_tdata,   // base_char
    input  logic                                s_axis_tuser,   // opcode
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tuple_index, tuple_count, qualifies, zero fill
    output logic [ksc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tuser,   // result_kind
    output logic                                m_axis_tlast,   // scan_last
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ksc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [ksc_pkg::CNT_W-1:0]           i_cfg_data
);

    localparam int IW = 2 * MAX_TUPLE_LEN;
    localparam int QW = IW + 2;

    logic [ksc_pkg::LEN_W-1:0] r_tuple_length;
    logic [ksc_pkg::CNT_W-1:0] r_multiplicity;
    logic [ksc_pkg::LEN_W-1:0] w_len_eff;
    logic                      w_clear_done;
    logic                      w_q_push;
    logic                      w_q_pop;
    logic                      w_q_full;
    logic                      w_q_empty;
    logic [QW-1:0]             w_q_wdata;
    logic [QW-1:0]             w_q_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tuple_length <= ksc_pkg::TUPLE_LENGTH_RST;
            r_multiplicity <= ksc_pkg::MULTIPLICITY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == ksc_pkg::CFG_TUPLE_LENGTH) begin
                r_tuple_length <= i_cfg_data[ksc_pkg::LEN_W-1:0];
            end else if (i_cfg_index == ksc_pkg::CFG_MULTIPLICITY) begin
                r_multiplicity <= i_cfg_data;
            end
        end
    end

    always_comb begin
        priority if (r_tuple_length == '0) begin
            w_len_eff = ksc_pkg::LEN_W'(1);
        end else if (r_tuple_length > ksc_pkg::LEN_W'(MAX_TUPLE_LEN)) begin
            w_len_eff = ksc_pkg::LEN_W'(MAX_TUPLE_LEN);
        end else begin
            w_len_eff = r_tuple_length;
        end
    end

    ksc_front #(
        .MAX_TUPLE_LEN (MAX_TUPLE_LEN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_len         (w_len_eff),
        .i_clear_done  (w_clear_done),
        .i_q_full      (w_q_full),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_q_push      (w_q_push),
        .o_q_data      (w_q_wdata)
    );

    ksc_queue #(
        .WIDTH (QW),
        .DEPTH (ksc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    ksc_back #(
        .MAX_TUPLE_LEN (MAX_TUPLE_LEN)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mult        (r_multiplicity),
        .i_q_empty     (w_q_empty),
        .i_q_data      (w_q_rdata),
        .o_q_pop       (w_q_pop),
        .o_clear_done  (w_clear_done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    `KSC_ASSERT_IMP(a_no_input_during_clear, i_clk, i_rst_n, s_axis_tready, w_clear_done)
    `KSC_ASSERT_IMP(a_push_has_room, i_clk, i_rst_n, w_q_push, !w_q_full)
    `KSC_ASSERT_IMP(a_last_only_on_scan, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser)
    `KSC_ASSERT_NXT(a_push_fills_queue, i_clk, i_rst_n, w_q_push && !w_q_pop, !w_q_empty)

endmodule
